// ----- rtl/gasp_pkg.sv -----
`default_nettype none
package gasp_pkg;

    // Request operation codes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_GRID_W     = 3'd0;
    localparam logic [2:0] CFG_GRID_H     = 3'd1;
    localparam logic [2:0] CFG_PASS_A     = 3'd2;
    localparam logic [2:0] CFG_PASS_B     = 3'd3;
    localparam logic [2:0] CFG_PASS_C     = 3'd4;
    localparam logic [2:0] CFG_USE_SHADOW = 3'd5;

    // Cell status codes
    localparam logic [1:0] ST_FREE   = 2'd0;
    localparam logic [1:0] ST_OPEN   = 2'd1;
    localparam logic [1:0] ST_CLOSED = 2'd2;

    // Neighbor directions, in visiting order
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    localparam int CRD_W = 9;
    typedef logic signed [CRD_W-1:0] t_crd;

    function automatic t_crd step_dx(input logic [1:0] d);
        case (d)
            DIR_LEFT:  return t_crd'(-1);
            DIR_RIGHT: return t_crd'(1);
            default:   return t_crd'(0);
        endcase
    endfunction

    function automatic t_crd step_dy(input logic [1:0] d);
        case (d)
            DIR_UP:   return t_crd'(-1);
            DIR_DOWN: return t_crd'(1);
            default:  return t_crd'(0);
        endcase
    endfunction

endpackage
`default_nettype wire

// ----- rtl/grid_astar_path_search_top.sv -----
`default_nettype none
// Grid path search: A* over a 4-connected grid, unit step cost, Manhattan estimate.
// Request channel: start/busy; a request is taken on a clock edge with start high and
// busy low. i_operation selects: load one cell (block id and shadow bit into the map),
// run a search from start to goal, or read one step of the last found path.
// Result channel: o_result_valid strobes for one cycle with found, path length and the
// step coordinates. The receiver cannot stall; every result is taken in its cycle.
// Configuration channel: i_cfg_valid/o_cfg_ready with a register index and data; write
// only while busy is low and no result is pending.
// Timing: a load answers in the cycle after the request and busy stays low, so loads
// run one per cycle. A path read holds busy for one cycle (S_RDOUT) and answers from the
// registered path memory word. A search first sweeps the node memory to clear every cell
// status, then for each expansion issues and evaluates each in-grid neighbor in turn,
// makes one pass over the w*h cells in use to pick the open cell of lowest f, and closes
// it. Building the path writes one path cell, then steps back along the parent direction,
// cell by cell. The node memory has a single read port, which keeps these steps in turn.
// Reset: configuration returns to its reset values, found and path length clear; map
// and path memories hold undefined contents until written.
module grid_astar_path_search_top #(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_operation,
    input  wire logic [11:0] i_cell_index,
    input  wire logic [7:0]  i_block_id,
    input  wire logic        i_shadow_open,
    input  wire logic [5:0]  i_start_x,
    input  wire logic [5:0]  i_start_y,
    input  wire logic [5:0]  i_goal_x,
    input  wire logic [5:0]  i_goal_y,
    input  wire logic [11:0] i_step_index,
    output logic             o_result_valid,
    output logic             o_found,
    output logic [12:0]      o_path_length,
    output logic [5:0]       o_step_x,
    output logic [5:0]       o_step_y,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    localparam int NCELLS = GRID_W * GRID_H;
    localparam int AW     = $clog2(NCELLS);
    localparam int PAW    = $clog2(NCELLS + 1);
    localparam int CW     = $clog2(NCELLS) + 1;
    localparam int FW     = CW + 8;
    localparam int PW     = 16;
    localparam int NW     = 2 * CW + 4;
    // node record layout: status, cost, parent direction, insert order
    localparam int CO_LO  = 2;
    localparam int DR_LO  = CW + 2;
    localparam int OR_LO  = CW + 4;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RDOUT  = 4'd1;
    localparam logic [3:0] S_CLEAR  = 4'd2;
    localparam logic [3:0] S_START  = 4'd3;
    localparam logic [3:0] S_NISSUE = 4'd4;
    localparam logic [3:0] S_NEVAL  = 4'd5;
    localparam logic [3:0] S_SCAN   = 4'd6;
    localparam logic [3:0] S_CLOSE  = 4'd7;
    localparam logic [3:0] S_BWRITE = 4'd8;
    localparam logic [3:0] S_BSTEP  = 4'd9;

    // memories
    logic [8:0]     map_mem  [NCELLS];
    logic [NW-1:0]  node_mem [NCELLS];
    logic [11:0]    path_mem [NCELLS + 1];

    logic [3:0]     r_state;
    logic [6:0]     r_gw, r_gh;
    logic [7:0]     r_pass_a, r_pass_b, r_pass_c;
    logic           r_use_shadow;
    logic           r_res_valid, r_found;
    logic [CW-1:0]  r_count;
    logic [5:0]     r_step_x, r_step_y;
    logic [11:0]    r_si;
    logic [5:0]     r_sx, r_sy, r_gx, r_gy;
    logic [AW:0]    r_ncell;
    logic [AW-1:0]  r_clr;
    gasp_pkg::t_crd r_cx, r_cy, r_bx, r_by;
    logic [CW-1:0]  r_g, r_ins, r_bk;
    logic [1:0]     r_dir;
    logic [AW-1:0]  r_pidx;
    logic [AW-1:0]  r_sc_idx, r_sc_pidx;
    logic [6:0]     r_sc_x, r_sc_y, r_sc_px, r_sc_py;
    logic           r_sc_more, r_sc_pv;
    logic           r_best_v;
    logic [AW-1:0]  r_best_idx;
    logic [FW-1:0]  r_best_f;
    logic [CW-1:0]  r_best_o, r_best_g;
    logic [1:0]     r_best_d;
    logic [6:0]     r_best_x, r_best_y;
    logic [8:0]     r_map_rd;
    logic [NW-1:0]  r_node_rd;
    logic [11:0]    r_path_rd;

    logic [6:0]     eff_w, eff_h;
    gasp_pkg::t_crd nb_x, nb_y;
    logic           nb_goal, nb_in, nb_adv;
    logic [AW-1:0]  nb_idx, bd_idx, start_idx;
    logic           start_in;
    logic           acc;
    logic           pass_ok, upd;
    logic [1:0]     rd_st;
    logic [CW-1:0]  rd_cost, rd_ord, g_inc;
    logic [1:0]     rd_dir;
    logic [8:0]     dxs, dys;
    logic [7:0]     dxa, dya;
    logic [FW-1:0]  sc_f;
    logic           sc_better;
    logic [AW-1:0]  node_ra, node_wa;
    logic           node_we;
    logic [NW-1:0]  node_wd;
    logic           path_we;
    logic [PAW-1:0] path_wa;
    logic [11:0]    path_wd;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign acc         = start && !busy;

    assign o_result_valid = r_res_valid;
    assign o_found        = r_found;
    assign o_path_length  = 13'(r_count);
    assign o_step_x       = r_step_x;
    assign o_step_y       = r_step_y;

    // clamp grid size to the memory's shape
    always_comb begin
        eff_w = r_gw;
        if (r_gw == 7'd0) begin
            eff_w = 7'd1;
        end else if ({2'b0, r_gw} > 9'(GRID_W)) begin
            eff_w = 7'(GRID_W);
        end
        eff_h = r_gh;
        if (r_gh == 7'd0) begin
            eff_h = 7'd1;
        end else if ({2'b0, r_gh} > 9'(GRID_H)) begin
            eff_h = 7'(GRID_H);
        end
    end

    // neighbor of the node under expansion
    assign nb_x    = r_cx + gasp_pkg::step_dx(r_dir);
    assign nb_y    = r_cy + gasp_pkg::step_dy(r_dir);
    assign nb_goal = (nb_x == $signed({3'b0, r_gx})) && (nb_y == $signed({3'b0, r_gy}));
    assign nb_in   = (nb_x >= 0) && (nb_y >= 0)
                     && (nb_x < $signed({2'b0, eff_w})) && (nb_y < $signed({2'b0, eff_h}));
    assign nb_idx  = AW'(PW'(nb_y[7:0]) * PW'(eff_w) + PW'(nb_x[7:0]));
    assign bd_idx  = AW'(PW'(r_by[7:0]) * PW'(eff_w) + PW'(r_bx[7:0]));
    assign start_idx = AW'(PW'(r_sy) * PW'(eff_w) + PW'(r_sx));
    assign start_in  = ({1'b0, r_sx} < eff_w) && ({1'b0, r_sy} < eff_h);

    assign rd_st   = r_node_rd[1:0];
    assign rd_cost = r_node_rd[CO_LO +: CW];
    assign rd_dir  = r_node_rd[DR_LO +: 2];
    assign rd_ord  = r_node_rd[OR_LO +: CW];
    assign g_inc   = r_g + CW'(1);

    assign pass_ok = ((r_map_rd[7:0] == r_pass_a) || (r_map_rd[7:0] == r_pass_b)
                      || (r_map_rd[7:0] == r_pass_c)) && (!r_use_shadow || r_map_rd[8]);
    assign upd     = pass_ok && (rd_st != gasp_pkg::ST_CLOSED)
                     && ((rd_st == gasp_pkg::ST_FREE) || (g_inc < rd_cost));

    // advance to the next neighbor, or on to the scan after the last one
    assign nb_adv  = ((r_state == S_NISSUE) && !nb_goal && !nb_in) || (r_state == S_NEVAL);

    // f of the cell whose record arrives this cycle
    assign dxs = $signed({2'b0, r_sc_px}) - $signed({3'b0, r_gx});
    assign dys = $signed({2'b0, r_sc_py}) - $signed({3'b0, r_gy});
    assign dxa = dxs[8] ? 8'(-dxs) : dxs[7:0];
    assign dya = dys[8] ? 8'(-dys) : dys[7:0];
    assign sc_f = FW'(rd_cost) + FW'(dxa) + FW'(dya);
    assign sc_better = (rd_st == gasp_pkg::ST_OPEN)
                       && (!r_best_v || (sc_f < r_best_f)
                           || ((sc_f == r_best_f) && (rd_ord < r_best_o)));

    // node memory port control
    always_comb begin
        node_we = 1'b0;
        node_wa = r_pidx;
        node_wd = '0;
        case (r_state)
            S_CLEAR: begin
                node_we = 1'b1;
                node_wa = r_clr;
            end
            S_START: begin
                node_we = start_in;
                node_wa = start_idx;
                node_wd[1:0] = gasp_pkg::ST_CLOSED;
            end
            S_NEVAL: begin
                node_we = upd;
                node_wd = {r_ins, r_dir, g_inc, gasp_pkg::ST_OPEN};
            end
            S_CLOSE: begin
                node_we = 1'b1;
                node_wa = r_best_idx;
                node_wd = {r_best_o, r_best_d, r_best_g, gasp_pkg::ST_CLOSED};
            end
            default: begin
                node_we = 1'b0;
            end
        endcase
        case (r_state)
            S_SCAN:   node_ra = r_sc_idx;
            S_BWRITE: node_ra = bd_idx;
            default:  node_ra = nb_idx;
        endcase
    end

    // path memory write: goal at the far end, then the chain back to the start
    always_comb begin
        path_we = 1'b0;
        path_wa = PAW'(g_inc);
        path_wd = {r_gy, r_gx};
        if ((r_state == S_NISSUE) && nb_goal) begin
            path_we = 1'b1;
        end else if (r_state == S_BWRITE) begin
            path_we = 1'b1;
            path_wa = PAW'(r_bk - CW'(1));
            path_wd = {r_by[5:0], r_bx[5:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && (i_operation == gasp_pkg::OP_LOAD) && (32'(i_cell_index) < NCELLS)) begin
            map_mem[AW'(i_cell_index)] <= {i_shadow_open, i_block_id};
        end
        r_map_rd <= map_mem[nb_idx];
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[node_wa] <= node_wd;
        end
        r_node_rd <= node_mem[node_ra];
    end

    always_ff @(posedge i_clk) begin
        if (path_we) begin
            path_mem[path_wa] <= path_wd;
        end
        r_path_rd <= path_mem[PAW'(i_step_index)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_gw         <= 7'd64;
            r_gh         <= 7'd64;
            r_pass_a     <= 8'd0;
            r_pass_b     <= 8'd0;
            r_pass_c     <= 8'd0;
            r_use_shadow <= 1'b0;
            r_res_valid  <= 1'b0;
            r_found      <= 1'b0;
            r_count      <= '0;
            r_ins        <= '0;
            r_sc_more    <= 1'b0;
            r_sc_pv      <= 1'b0;
            r_best_v     <= 1'b0;
            r_dir        <= gasp_pkg::DIR_UP;
        end else begin
            r_res_valid <= 1'b0;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    gasp_pkg::CFG_GRID_W:     r_gw <= i_cfg_data[6:0];
                    gasp_pkg::CFG_GRID_H:     r_gh <= i_cfg_data[6:0];
                    gasp_pkg::CFG_PASS_A:     r_pass_a <= i_cfg_data;
                    gasp_pkg::CFG_PASS_B:     r_pass_b <= i_cfg_data;
                    gasp_pkg::CFG_PASS_C:     r_pass_c <= i_cfg_data;
                    gasp_pkg::CFG_USE_SHADOW: r_use_shadow <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        case (i_operation)
                            gasp_pkg::OP_SEARCH: begin
                                r_sx    <= i_start_x;
                                r_sy    <= i_start_y;
                                r_gx    <= i_goal_x;
                                r_gy    <= i_goal_y;
                                r_found <= 1'b0;
                                r_count <= '0;
                                r_ins   <= '0;
                                r_clr   <= '0;
                                r_ncell <= (AW+1)'(PW'(eff_w) * PW'(eff_h));
                                r_state <= S_CLEAR;
                            end
                            gasp_pkg::OP_READ: begin
                                r_si    <= i_step_index;
                                r_state <= S_RDOUT;
                            end
                            default: begin
                                // load or unused code: answer at once
                                r_res_valid <= 1'b1;
                                r_step_x    <= 6'd0;
                                r_step_y    <= 6'd0;
                            end
                        endcase
                    end
                end
                S_RDOUT: begin
                    r_res_valid <= 1'b1;
                    if (32'(r_si) < 32'(r_count)) begin
                        r_step_x <= r_path_rd[5:0];
                        r_step_y <= r_path_rd[11:6];
                    end else begin
                        r_step_x <= 6'd0;
                        r_step_y <= 6'd0;
                    end
                    r_state <= S_IDLE;
                end
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(NCELLS - 1)) begin
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_cx    <= gasp_pkg::t_crd'({3'b0, r_sx});
                    r_cy    <= gasp_pkg::t_crd'({3'b0, r_sy});
                    r_g     <= '0;
                    r_dir   <= gasp_pkg::DIR_UP;
                    r_state <= S_NISSUE;
                end
                S_NISSUE: begin
                    if (nb_goal) begin
                        r_bk    <= g_inc;
                        r_bx    <= r_cx;
                        r_by    <= r_cy;
                        r_state <= S_BWRITE;
                    end else if (nb_in) begin
                        r_pidx  <= nb_idx;
                        r_state <= S_NEVAL;
                    end
                end
                S_NEVAL: begin
                    if (upd) begin
                        r_ins <= r_ins + CW'(1);
                    end
                    r_state <= S_NISSUE;
                end
                S_SCAN: begin
                    if (r_sc_pv && sc_better) begin
                        r_best_v   <= 1'b1;
                        r_best_idx <= r_sc_pidx;
                        r_best_f   <= sc_f;
                        r_best_o   <= rd_ord;
                        r_best_g   <= rd_cost;
                        r_best_d   <= rd_dir;
                        r_best_x   <= r_sc_px;
                        r_best_y   <= r_sc_py;
                    end
                    if (r_sc_more) begin
                        r_sc_pv   <= 1'b1;
                        r_sc_pidx <= r_sc_idx;
                        r_sc_px   <= r_sc_x;
                        r_sc_py   <= r_sc_y;
                        if ({1'b0, r_sc_idx} == r_ncell - (AW+1)'(1)) begin
                            r_sc_more <= 1'b0;
                        end else begin
                            r_sc_idx <= r_sc_idx + AW'(1);
                            if (r_sc_x == eff_w - 7'd1) begin
                                r_sc_x <= 7'd0;
                                r_sc_y <= r_sc_y + 7'd1;
                            end else begin
                                r_sc_x <= r_sc_x + 7'd1;
                            end
                        end
                    end else begin
                        r_sc_pv <= 1'b0;
                        if (!r_sc_pv) begin
                            if (r_best_v) begin
                                r_state <= S_CLOSE;
                            end else begin
                                // open set exhausted: no path
                                r_res_valid <= 1'b1;
                                r_step_x    <= 6'd0;
                                r_step_y    <= 6'd0;
                                r_state     <= S_IDLE;
                            end
                        end
                    end
                end
                S_CLOSE: begin
                    r_cx    <= gasp_pkg::t_crd'({2'b0, r_best_x});
                    r_cy    <= gasp_pkg::t_crd'({2'b0, r_best_y});
                    r_g     <= r_best_g;
                    r_dir   <= gasp_pkg::DIR_UP;
                    r_state <= S_NISSUE;
                end
                S_BWRITE: begin
                    if (r_bk == CW'(1)) begin
                        r_found     <= 1'b1;
                        r_count     <= r_g + CW'(2);
                        r_res_valid <= 1'b1;
                        r_step_x    <= 6'd0;
                        r_step_y    <= 6'd0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_BSTEP;
                    end
                end
                S_BSTEP: begin
                    // walk back along the parent direction
                    r_bx    <= r_bx - gasp_pkg::step_dx(rd_dir);
                    r_by    <= r_by - gasp_pkg::step_dy(rd_dir);
                    r_bk    <= r_bk - CW'(1);
                    r_state <= S_BWRITE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (nb_adv) begin
                if (r_dir == gasp_pkg::DIR_RIGHT) begin
                    r_sc_idx  <= '0;
                    r_sc_x    <= 7'd0;
                    r_sc_y    <= 7'd0;
                    r_sc_more <= 1'b1;
                    r_sc_pv   <= 1'b0;
                    r_best_v  <= 1'b0;
                    r_state   <= S_SCAN;
                end else begin
                    r_dir <= r_dir + 2'd1;
                end
            end
        end
    end

    // load requests answer in the next cycle
    a_load_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_operation == gasp_pkg::OP_LOAD)) |=> o_result_valid)
        else $error("load request did not answer");

    // a search holds the block busy while it runs
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_operation == gasp_pkg::OP_SEARCH)) |=> (busy && !o_result_valid))
        else $error("search did not start");

    // scan pipeline only carries data inside the scan
    a_scan_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sc_pv |-> (r_state == S_SCAN))
        else $error("scan data outside scan");

    // no result during the clearing sweep
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_result_valid)
        else $error("result during clear");

endmodule
`default_nettype wire
